FILE: src/gda_pkg.sv
package gda_pkg;

    localparam int CMD_W       = 2;
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int DAY_COUNT_W = 12;
    localparam int DIFF_W      = 22;

    localparam int COUNT_BITS = 12;
    localparam int CNT_W      = (COUNT_BITS < DAY_COUNT_W) ? COUNT_BITS : DAY_COUNT_W;
    localparam int SUM_W      = ((CNT_W > DAY_W) ? CNT_W : DAY_W) + 2;

    localparam int LEAP_CYCLE     = 400;
    localparam int CENTURY        = 100;
    localparam int DAYS_PER_YEAR  = 365;
    localparam int M400_W         = 9;
    localparam int Q400_W         = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_LAST  = DAY_W'(31);
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = DAY_W'(29);
    localparam logic [M400_W-1:0]  M400_LAST = M400_W'(LEAP_CYCLE - 1);

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
        DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
    };

    localparam logic [8:0] CUM_DAYS [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 2'd0,
        CMD_SUB  = 2'd1,
        CMD_CMP  = 2'd2,
        CMD_DIFF = 2'd3
    } cmd_t;

    localparam int S_FIELDS_W = 2 * (YEAR_W + MONTH_W + DAY_W) + DAY_COUNT_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic [S_DATA_W-S_FIELDS_W-1:0] pad;
        logic [DAY_COUNT_W-1:0]         day_count;
        logic [DAY_W-1:0]               other_day;
        logic [MONTH_W-1:0]             other_month;
        logic [YEAR_W-1:0]              other_year;
        logic [DAY_W-1:0]               day_in;
        logic [MONTH_W-1:0]             month_in;
        logic [YEAR_W-1:0]              year_in;
    } s_data_t;

    typedef struct packed {
        logic                    out_of_range;
        logic [DIFF_W-1:0]       day_difference;
        logic                    is_equal;
        logic                    is_greater;
        logic [DAY_W-1:0]        new_day;
        logic [MONTH_W-1:0]      new_month;
        logic [YEAR_W-1:0]       new_year;
    } result_t;

    localparam int M_DATA_W = $bits(result_t);

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [M400_W-1:0]  m400;
        logic [Q400_W-1:0]  q400;
    } date_t;

    typedef struct packed {
        cmd_t             cmd;
        date_t            a;
        date_t            b;
        logic [CNT_W-1:0] count;
    } item_t;

    typedef struct packed {
        logic [Q400_W-1:0] q;
        logic [M400_W-1:0] r;
    } div400_t;

    function automatic logic is_leap(input logic [M400_W-1:0] m400);
        return (m400[1:0] == 2'b00) && (m400 != M400_W'(CENTURY))
            && (m400 != M400_W'(2 * CENTURY)) && (m400 != M400_W'(3 * CENTURY));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        if (month == MONTH_FEB && leap) begin
            return FEB_LEAP_LEN;
        end
        return MONTH_LEN[month - MONTH_JAN];
    endfunction

    function automatic div400_t div400(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] r;
        logic [Q400_W-1:0] q;
        div400_t           res;
        r = y;
        q = '0;
        for (int i = Q400_W - 1; i >= 0; i--) begin
            if (r >= YEAR_W'(LEAP_CYCLE << i)) begin
                r    = r - YEAR_W'(LEAP_CYCLE << i);
                q[i] = 1'b1;
            end
        end
        res.q = q;
        res.r = r[M400_W-1:0];
        return res;
    endfunction

    function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
        if (y < YEAR_MIN) begin
            return YEAR_MIN;
        end
        if (y > YEAR_MAX) begin
            return YEAR_MAX;
        end
        return y;
    endfunction

    function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
        if (m < MONTH_JAN) begin
            return MONTH_JAN;
        end
        if (m > MONTH_DEC) begin
            return MONTH_DEC;
        end
        return m;
    endfunction

endpackage

FILE: src/gda_front.sv
module gda_front
    import gda_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]    s_tuser,
    output logic                push_valid,
    input  logic                push_ready,
    output item_t               push_item
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MOD  = 4'b0010,
        F_DAY  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t     state_reg, state_next;
    item_t            item_reg, item_next;
    logic [DAY_W-1:0] raw_a_reg, raw_a_next;
    logic [DAY_W-1:0] raw_b_reg, raw_b_next;

    s_data_t          s_data;
    div400_t          div_a, div_b;
    logic [DAY_W-1:0] len_a, len_b;

    assign s_data = s_data_t'(s_tdata);
    assign div_a  = div400(item_reg.a.year);
    assign div_b  = div400(item_reg.b.year);
    assign len_a  = days_in(item_reg.a.month, is_leap(item_reg.a.m400));
    assign len_b  = days_in(item_reg.b.month, is_leap(item_reg.b.m400));

    assign s_tready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_item  = item_reg;

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        raw_a_next = raw_a_reg;
        raw_b_next = raw_b_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    item_next.cmd     = cmd_t'(s_tuser);
                    item_next.a.year  = clamp_year(s_data.year_in);
                    item_next.a.month = clamp_month(s_data.month_in);
                    item_next.b.year  = clamp_year(s_data.other_year);
                    item_next.b.month = clamp_month(s_data.other_month);
                    item_next.count   = s_data.day_count[CNT_W-1:0];
                    raw_a_next        = s_data.day_in;
                    raw_b_next        = s_data.other_day;
                    state_next        = F_MOD;
                end
            end
            F_MOD: begin
                item_next.a.m400 = div_a.r;
                item_next.a.q400 = div_a.q;
                item_next.b.m400 = div_b.r;
                item_next.b.q400 = div_b.q;
                state_next       = F_DAY;
            end
            F_DAY: begin
                item_next.a.day = (raw_a_reg < DAY_FIRST) ? DAY_FIRST
                                : ((raw_a_reg > len_a) ? len_a : raw_a_reg);
                item_next.b.day = (raw_b_reg < DAY_FIRST) ? DAY_FIRST
                                : ((raw_b_reg > len_b) ? len_b : raw_b_reg);
                state_next      = F_PUSH;
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        raw_a_reg <= raw_a_next;
        raw_b_reg <= raw_b_next;
    end

endmodule

FILE: src/gda_queue.sv
module gda_queue
    import gda_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/gda_back.sv
module gda_back
    import gda_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  item_t               pop_item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_ADD  = 7'b0000010,
        B_SUB  = 7'b0000100,
        B_DN1  = 7'b0001000,
        B_DN2  = 7'b0010000,
        B_DN3  = 7'b0100000,
        B_EMIT = 7'b1000000
    } back_state_t;

    back_state_t              state_reg, state_next;
    item_t                    item_reg, item_next;
    logic [YEAR_W-1:0]        y_reg, y_next;
    logic [MONTH_W-1:0]       m_reg, m_next;
    logic [M400_W-1:0]        m400_reg, m400_next;
    logic signed [SUM_W-1:0]  d_reg, d_next;
    result_t                  res_reg, res_next;
    logic [DIFF_W-1:0]        prod_a_reg, prod_a_next, prod_b_reg, prod_b_next;
    logic [DIFF_W-1:0]        ext_a_reg, ext_a_next, ext_b_reg, ext_b_next;
    logic [DIFF_W-1:0]        num_a_reg, num_a_next, num_b_reg, num_b_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    result_t                  m_tdata_reg, m_tdata_next;

    logic                     out_free;
    logic signed [SUM_W-1:0]  head_day, head_count;
    logic [DAY_W-1:0]         cur_len, prev_len;
    logic [YEAR_W-1:0]        prev_y;
    logic [MONTH_W-1:0]       prev_m;
    logic [M400_W-1:0]        prev_m400;

    function automatic logic [DIFF_W-1:0] dn_ext(input date_t x);
        logic [YEAR_W-1:0] p;
        logic [M400_W-1:0] pm;
        logic [Q400_W-1:0] pq;
        logic [1:0]        c100;
        logic              feb_adj;
        p  = x.year - YEAR_W'(1);
        pm = (x.m400 == '0) ? M400_LAST : x.m400 - M400_W'(1);
        pq = (x.m400 == '0) ? x.q400 - Q400_W'(1) : x.q400;
        c100 = (pm >= M400_W'(3 * CENTURY)) ? 2'd3
             : (pm >= M400_W'(2 * CENTURY)) ? 2'd2
             : (pm >= M400_W'(CENTURY))     ? 2'd1 : 2'd0;
        feb_adj = (x.month > MONTH_FEB) && is_leap(x.m400);
        return DIFF_W'(p >> 2) - DIFF_W'({pq, 2'b00}) - DIFF_W'(c100) + DIFF_W'(pq)
             + DIFF_W'(CUM_DAYS[x.month - MONTH_JAN]) + DIFF_W'(feb_adj) + DIFF_W'(x.day);
    endfunction

    assign out_free   = !m_tvalid_reg || m_tready;
    assign pop_ready  = (state_reg == B_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    assign head_day   = $signed({{(SUM_W - DAY_W){1'b0}}, pop_item.a.day});
    assign head_count = $signed({{(SUM_W - CNT_W){1'b0}}, pop_item.count});

    assign cur_len   = days_in(m_reg, is_leap(m400_reg));
    assign prev_y    = (m_reg == MONTH_JAN) ? y_reg - YEAR_W'(1) : y_reg;
    assign prev_m    = (m_reg == MONTH_JAN) ? MONTH_DEC : m_reg - MONTH_W'(1);
    assign prev_m400 = (m_reg != MONTH_JAN) ? m400_reg
                     : ((m400_reg == '0) ? M400_LAST : m400_reg - M400_W'(1));
    assign prev_len  = days_in(prev_m, is_leap(prev_m400));

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        y_next        = y_reg;
        m_next        = m_reg;
        m400_next     = m400_reg;
        d_next        = d_reg;
        res_next      = res_reg;
        prod_a_next   = prod_a_reg;
        prod_b_next   = prod_b_reg;
        ext_a_next    = ext_a_reg;
        ext_b_next    = ext_b_reg;
        num_a_next    = num_a_reg;
        num_b_next    = num_b_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    item_next = pop_item;
                    y_next    = pop_item.a.year;
                    m_next    = pop_item.a.month;
                    m400_next = pop_item.a.m400;
                    res_next  = '0;
                    case (pop_item.cmd)
                        CMD_ADD: begin
                            d_next     = head_day + head_count;
                            state_next = B_ADD;
                        end
                        CMD_SUB: begin
                            d_next     = head_day - head_count;
                            state_next = B_SUB;
                        end
                        CMD_CMP: begin
                            res_next.is_greater =
                                {pop_item.a.year, pop_item.a.month, pop_item.a.day} >
                                {pop_item.b.year, pop_item.b.month, pop_item.b.day};
                            res_next.is_equal =
                                {pop_item.a.year, pop_item.a.month, pop_item.a.day} ==
                                {pop_item.b.year, pop_item.b.month, pop_item.b.day};
                            state_next = B_EMIT;
                        end
                        default: begin
                            state_next = B_DN1;
                        end
                    endcase
                end
            end
            B_ADD: begin
                if (d_reg > $signed({{(SUM_W - DAY_W){1'b0}}, cur_len})) begin
                    d_next = d_reg - $signed({{(SUM_W - DAY_W){1'b0}}, cur_len});
                    if (m_reg == MONTH_DEC) begin
                        if (y_reg == YEAR_MAX) begin
                            res_next.new_year     = YEAR_MAX;
                            res_next.new_month    = MONTH_DEC;
                            res_next.new_day      = DAY_LAST;
                            res_next.out_of_range = 1'b1;
                            state_next            = B_EMIT;
                        end else begin
                            y_next    = y_reg + YEAR_W'(1);
                            m_next    = MONTH_JAN;
                            m400_next = (m400_reg == M400_LAST) ? '0
                                      : m400_reg + M400_W'(1);
                        end
                    end else begin
                        m_next = m_reg + MONTH_W'(1);
                    end
                end else begin
                    res_next.new_year  = y_reg;
                    res_next.new_month = m_reg;
                    res_next.new_day   = d_reg[DAY_W-1:0];
                    state_next         = B_EMIT;
                end
            end
            B_SUB: begin
                if (d_reg <= $signed(SUM_W'(0))) begin
                    if (m_reg == MONTH_JAN && y_reg == YEAR_MIN) begin
                        res_next.new_year     = YEAR_MIN;
                        res_next.new_month    = MONTH_JAN;
                        res_next.new_day      = DAY_FIRST;
                        res_next.out_of_range = 1'b1;
                        state_next            = B_EMIT;
                    end else begin
                        y_next    = prev_y;
                        m_next    = prev_m;
                        m400_next = prev_m400;
                        d_next    = d_reg + $signed({{(SUM_W - DAY_W){1'b0}}, prev_len});
                    end
                end else begin
                    res_next.new_year  = y_reg;
                    res_next.new_month = m_reg;
                    res_next.new_day   = d_reg[DAY_W-1:0];
                    state_next         = B_EMIT;
                end
            end
            B_DN1: begin
                prod_a_next = DIFF_W'(item_reg.a.year - YEAR_W'(1)) * DIFF_W'(DAYS_PER_YEAR);
                prod_b_next = DIFF_W'(item_reg.b.year - YEAR_W'(1)) * DIFF_W'(DAYS_PER_YEAR);
                ext_a_next  = dn_ext(item_reg.a);
                ext_b_next  = dn_ext(item_reg.b);
                state_next  = B_DN2;
            end
            B_DN2: begin
                num_a_next = prod_a_reg + ext_a_reg;
                num_b_next = prod_b_reg + ext_b_reg;
                state_next = B_DN3;
            end
            B_DN3: begin
                res_next.day_difference = (num_a_reg > num_b_reg) ? num_a_reg - num_b_reg : '0;
                state_next              = B_EMIT;
            end
            B_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        y_reg       <= y_next;
        m_reg       <= m_next;
        m400_reg    <= m400_next;
        d_reg       <= d_next;
        res_reg     <= res_next;
        prod_a_reg  <= prod_a_next;
        prod_b_reg  <= prod_b_next;
        ext_a_reg   <= ext_a_next;
        ext_b_reg   <= ext_b_next;
        num_a_reg   <= num_a_next;
        num_b_reg   <= num_b_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

FILE: src/gregorian_date_arithmetic_top.sv
// Gregorian date arithmetic on a stream: each input beat carries a command in s_tuser
// (add days, subtract days, compare, day difference), two dates and a day count, and
// gives exactly one output beat. Dates are clamped field by field before use, and add or
// subtract saturates at 9999-12-31 or 0001-01-01 with out_of_range set. A front stage
// takes each beat through its steps in turn (capture and clamp of year and month, the year
// modulo 400, the day clamp, the hand-off into a two-entry queue) before it takes the next.
// In the back end, add or subtract walks the day count a month at a time by a single step
// that takes off (add) or adds back (subtract) one month length and carries into the
// month and year.
module gregorian_date_arithmetic_top
    import gda_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // year_in, month_in, day_in, other_year, other_month, other_day, day_count, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // command
    input  logic [CMD_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // new_year, new_month, new_day, is_greater, is_equal, day_difference, out_of_range
    output logic [M_DATA_W-1:0] m_tdata
);

    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    gda_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    gda_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    gda_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: tb/sv/gregorian_date_arithmetic_checker.sv
module gregorian_date_arithmetic_checker
    import gda_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // year_in, month_in, day_in, other_year, other_month, other_day, day_count, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // command
    input  logic [CMD_W-1:0]    s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // new_year, new_month, new_day, is_greater, is_equal, day_difference, out_of_range
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  fail_count,
    output int                  pending_count,
    output int                  checked_count,
    output int                  saturated_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        int unsigned y;
        int unsigned m;
        int unsigned d;
    } cal_date_t;

    result_t pending_results[$];
    result_t want;
    result_t got;

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(int unsigned y, int unsigned m);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic cal_date_t clamp_date(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                             logic [DAY_W-1:0] d);
        cal_date_t   r;
        int unsigned md;
        r.y = 32'((y < YEAR_MIN) ? YEAR_MIN : ((y > YEAR_MAX) ? YEAR_MAX : y));
        r.m = 32'((m < MONTH_JAN) ? MONTH_JAN : ((m > MONTH_DEC) ? MONTH_DEC : m));
        md  = month_days(r.y, r.m);
        r.d = (d < 1) ? 1 : ((d > md) ? md : 32'(d));
        return r;
    endfunction

    function automatic int unsigned day_serial(cal_date_t a);
        int unsigned p;
        int unsigned n;
        p = a.y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < a.m; k++) begin
            n += month_days(a.y, k);
        end
        return n + a.d;
    endfunction

    function automatic result_t calc_result(cmd_t c, s_data_t f);
        result_t     r;
        cal_date_t   a;
        cal_date_t   b;
        int unsigned sum;
        int unsigned md;
        int          rem;
        int unsigned na;
        int unsigned nb;
        r = '0;
        a = clamp_date(f.year_in, f.month_in, f.day_in);
        b = clamp_date(f.other_year, f.other_month, f.other_day);
        case (c)
            CMD_ADD: begin
                sum = a.d + 32'(f.day_count);
                while (1) begin
                    md = month_days(a.y, a.m);
                    if (sum <= md) break;
                    sum -= md;
                    if (a.m == MONTH_DEC) begin
                        if (a.y == YEAR_MAX) begin
                            sum = 32'(DAY_LAST);
                            r.out_of_range = 1'b1;
                            break;
                        end
                        a.y++;
                        a.m = 32'(MONTH_JAN);
                    end else begin
                        a.m++;
                    end
                end
                r.new_year  = YEAR_W'(a.y);
                r.new_month = MONTH_W'(a.m);
                r.new_day   = DAY_W'(sum);
            end
            CMD_SUB: begin
                rem = int'(a.d) - int'(f.day_count);
                while (rem <= 0) begin
                    if (a.m == MONTH_JAN) begin
                        if (a.y == YEAR_MIN) begin
                            rem = 1;
                            r.out_of_range = 1'b1;
                            break;
                        end
                        a.y--;
                        a.m = 32'(MONTH_DEC);
                    end else begin
                        a.m--;
                    end
                    rem += int'(month_days(a.y, a.m));
                end
                r.new_year  = YEAR_W'(a.y);
                r.new_month = MONTH_W'(a.m);
                r.new_day   = DAY_W'(rem);
            end
            CMD_CMP: begin
                if (a.y != b.y) begin
                    r.is_greater = a.y > b.y;
                end else if (a.m != b.m) begin
                    r.is_greater = a.m > b.m;
                end else if (a.d != b.d) begin
                    r.is_greater = a.d > b.d;
                end else begin
                    r.is_equal = 1'b1;
                end
            end
            default: begin
                na = day_serial(a);
                nb = day_serial(b);
                r.day_difference = (na > nb) ? DIFF_W'(na - nb) : '0;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", field, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_results.delete();
            pending_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("Result beat %h arrived with nothing outstanding.", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    got  = result_t'(m_tdata);
                    check_field("new_year", 32'(want.new_year), 32'(got.new_year));
                    check_field("new_month", 32'(want.new_month), 32'(got.new_month));
                    check_field("new_day", 32'(want.new_day), 32'(got.new_day));
                    check_field("is_greater", 32'(want.is_greater), 32'(got.is_greater));
                    check_field("is_equal", 32'(want.is_equal), 32'(got.is_equal));
                    check_field("day_difference", 32'(want.day_difference),
                                32'(got.day_difference));
                    check_field("out_of_range", 32'(want.out_of_range),
                                32'(got.out_of_range));
                    checked_count++;
                    if (want.out_of_range) begin
                        saturated_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_results.push_back(calc_result(cmd_t'(s_tuser), s_data_t'(s_tdata)));
            end
            pending_count = pending_results.size();
        end
    end

endmodule

FILE: tb/sv/gregorian_date_arithmetic_top_test.sv
module gregorian_date_arithmetic_top_test;
    import gda_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 1700;
    localparam int CALM_TAIL    = 200;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]    s_tuser = CMD_ADD;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending_count;
    int checked_count;
    int saturated_count;
    int sent_by_cmd [4];
    bit send_gaps = 1'b0;
    bit quiet = 1'b0;

    gregorian_date_arithmetic_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    gregorian_date_arithmetic_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .checked_count   (checked_count),
        .saturated_count (saturated_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic s_data_t make_fields(int y, int m, int d, int oy, int om, int od,
                                            int cnt);
        s_data_t f;
        f             = '0;
        f.year_in     = YEAR_W'(y);
        f.month_in    = MONTH_W'(m);
        f.day_in      = DAY_W'(d);
        f.other_year  = YEAR_W'(oy);
        f.other_month = MONTH_W'(om);
        f.other_day   = DAY_W'(od);
        f.day_count   = DAY_COUNT_W'(cnt);
        return f;
    endfunction

    function automatic int rand_year();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(0, (1 << YEAR_W) - 1);
            1, 2:    return $urandom_range(1, 12);
            3, 4:    return $urandom_range(9988, 9999);
            default: return $urandom_range(1, 9999);
        endcase
    endfunction

    function automatic int rand_month();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    endfunction

    function automatic int rand_day();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 31);
    endfunction

    function automatic int rand_count();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 40);
            2, 3, 4: return $urandom_range(0, 4095);
            default: return $urandom_range(0, 400);
        endcase
    endfunction

    task automatic send_beat(cmd_t c, s_data_t f);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = f;
        s_tuser  = c;
        do @(posedge aclk); while (!s_tready);
        sent_by_cmd[int'(c)]++;
        @(negedge aclk);
    endtask

    initial begin
        bit stalling;
        forever begin
            stalling = !quiet && $urandom_range(0, 1);
            repeat ($urandom_range(50, 300)) begin
                @(negedge aclk);
                if (stalling && !quiet && $urandom_range(0, 5) == 0) begin
                    m_tready = 1'b0;
                    repeat ($urandom_range(1, 15)) @(negedge aclk);
                end
                m_tready = 1'b1;
            end
        end
    end

    initial begin
        cmd_t    c;
        s_data_t f;
        int      y;
        int      m;
        int      d;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_beat(CMD_ADD, make_fields(2024, 2, 28, 0, 0, 0, 1));
        send_beat(CMD_ADD, make_fields(2023, 2, 28, 0, 0, 0, 1));
        send_beat(CMD_ADD, make_fields(1900, 2, 28, 0, 0, 0, 1));
        send_beat(CMD_ADD, make_fields(2000, 2, 28, 0, 0, 0, 1));
        send_beat(CMD_ADD, make_fields(2023, 12, 31, 0, 0, 0, 1));
        send_beat(CMD_ADD, make_fields(9999, 12, 31, 0, 0, 0, 1));
        send_beat(CMD_ADD, make_fields(9990, 6, 15, 9999, 12, 31, 4095));
        send_beat(CMD_ADD, make_fields(2024, 1, 31, 1, 1, 1, 0));
        send_beat(CMD_SUB, make_fields(1, 1, 1, 0, 0, 0, 1));
        send_beat(CMD_SUB, make_fields(5, 6, 15, 0, 0, 0, 4095));
        send_beat(CMD_SUB, make_fields(2024, 3, 1, 0, 0, 0, 1));
        send_beat(CMD_SUB, make_fields(2023, 3, 5, 0, 0, 0, 5));
        send_beat(CMD_SUB, make_fields(2000, 1, 1, 0, 0, 0, 4095));
        send_beat(CMD_ADD, make_fields(0, 0, 0, 0, 0, 0, 10));
        send_beat(CMD_SUB, make_fields(16383, 15, 31, 16383, 15, 31, 3));
        send_beat(CMD_ADD, make_fields(2023, 2, 31, 0, 0, 0, 0));
        send_beat(CMD_CMP, make_fields(2020, 5, 5, 2020, 5, 5, 0));
        send_beat(CMD_CMP, make_fields(2020, 5, 6, 2020, 5, 5, 4095));
        send_beat(CMD_CMP, make_fields(1, 1, 1, 9999, 12, 31, 0));
        send_beat(CMD_CMP, make_fields(2023, 2, 30, 2023, 2, 28, 0));
        send_beat(CMD_DIFF, make_fields(9999, 12, 31, 1, 1, 1, 0));
        send_beat(CMD_DIFF, make_fields(2024, 3, 1, 2024, 2, 28, 0));
        send_beat(CMD_DIFF, make_fields(2024, 2, 28, 2024, 3, 1, 0));
        send_beat(CMD_DIFF, make_fields(1600, 2, 29, 1600, 2, 29, 0));

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i % 100 == 0) begin
                send_gaps = (i < RANDOM_BEATS - CALM_TAIL) && ($urandom_range(0, 2) != 0);
            end
            if (i == RANDOM_BEATS - CALM_TAIL) begin
                quiet = 1'b1;
            end
            c = cmd_t'($urandom_range(0, 3));
            y = rand_year();
            m = rand_month();
            d = rand_day();
            case ($urandom_range(0, 3))
                0:       f = make_fields(y, m, d, y, m, d, rand_count());
                1:       f = make_fields(y, m, d, y, rand_month(), rand_day(), rand_count());
                default: f = make_fields(y, m, d, rand_year(), rand_month(), rand_day(),
                                         rand_count());
            endcase
            send_beat(c, f);
        end
        s_tvalid = 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Drove %0d beats: %0d add, %0d subtract, %0d compare, %0d difference.",
                 sent_by_cmd[0] + sent_by_cmd[1] + sent_by_cmd[2] + sent_by_cmd[3],
                 sent_by_cmd[0], sent_by_cmd[1], sent_by_cmd[2], sent_by_cmd[3]);
        $display("Checked %0d result beats, %0d of them saturated at a year bound.",
                 checked_count, saturated_count);
        if (fail_count == 0) begin
            $display("[gregorian_date_arithmetic_top] OK");
        end else begin
            $display("[gregorian_date_arithmetic_top] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timed out with %0d results outstanding.", pending_count);
        $display("[gregorian_date_arithmetic_top] ERROR");
        $finish;
    end

endmodule
